// ----- hw/rtl/prrs_pkg.sv -----
// ----------------------------------------------------------------------------
// prrs_pkg
// Shared types and constants of the prefix route RTT smoother: word formats,
// table entry layout, controller states and the controller/datapath link.
// ----------------------------------------------------------------------------
package prrs_pkg;

    // rtt arithmetic
    localparam int unsigned RTT_W         = 37;
    localparam logic [19:0] US_PER_SECOND = 20'd1000000;
    localparam logic [19:0] US_MAX        = 20'd999999;
    localparam logic [15:0] SEC_MAX       = 16'hFFFF;
    // 65536 s in microseconds, first value whose seconds do not fit 16 bits
    localparam logic [RTT_W-1:0] SAT_LIMIT = 37'd65536000000;
    // one second is 64 * 15625 us; rtt >> 6 is divided by 15625
    localparam logic [13:0] US_PER_SECOND_ODD = 14'd15625;
    // ceil(2^44 / 15625), exact quotient for dividends below 2^30
    localparam logic [30:0] SEC_RECIP       = 31'd1125899907;
    localparam int unsigned SEC_RECIP_SHIFT = 44;

    // prefix lengths
    localparam logic [5:0] FULL_PREFIX  = 6'd32;
    localparam logic [5:0] RESET_PREFIX = 6'd24;

    // register index on the configuration port
    localparam logic REG_NEW_ENTRY_PREFIX = 1'b0;

    // input word
    typedef struct packed {
        logic [31:0] dest_address;
        logic [15:0] sample_seconds;
        logic [19:0] sample_microseconds;
    } t_in_word;

    // output word
    typedef struct packed {
        logic        matched;
        logic [3:0]  entry_slot;
        logic        table_full;
        logic [15:0] smoothed_seconds;
        logic [19:0] smoothed_microseconds;
    } t_out_word;

    // one route table entry
    typedef struct packed {
        logic [31:0]      address;
        logic [5:0]       prefix;
        logic [RTT_W-1:0] rtt_us;
    } t_entry;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CMP,
        S_UPDATE,
        S_INSERT,
        S_DIV,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic calc_sample;
        logic step_idx;
        logic update;
        logic insert;
        logic set_full;
        logic div_step;
        logic load_out;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic hit;
        logic idx_zero;
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

// ----- hw/rtl/prrs_ctrl.sv -----
// ----------------------------------------------------------------------------
// prrs_ctrl
// Sequencer of the smoother: walks the table newest to oldest, picks update,
// insert or drop, runs the divider and hands the result word out.
// ----------------------------------------------------------------------------
module prrs_ctrl
    import prrs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = i_status.empty ? S_INSERT : S_CMP;
            end
            S_CMP: begin
                priority if (i_status.hit) begin
                    n_state = S_UPDATE;
                end else if (i_status.idx_zero) begin
                    n_state = i_status.full ? S_DONE : S_INSERT;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_UPDATE: n_state = S_DIV;
            S_INSERT: n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:   o_cmd.load_in     = w_accept;
            S_PREP:   o_cmd.calc_sample = 1'b1;
            S_CMP: begin
                o_cmd.step_idx = !i_status.hit && !i_status.idx_zero;
                o_cmd.set_full = !i_status.hit && i_status.idx_zero && i_status.full;
            end
            S_UPDATE: o_cmd.update      = 1'b1;
            S_INSERT: o_cmd.insert      = 1'b1;
            S_DIV:    o_cmd.div_step    = 1'b1;
            S_DONE:   o_cmd.load_out    = i_status.out_free;
            default:  o_cmd             = '0;
        endcase
    end

endmodule

// ----- hw/rtl/prrs_dp.sv -----
// ----------------------------------------------------------------------------
// prrs_dp
// Datapath of the smoother: route table memory, prefix compare, rtt averaging,
// reciprocal split into seconds and the output register.
// ----------------------------------------------------------------------------
module prrs_dp
    import prrs_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctrl_cmd  i_cmd,
    output t_dp_status o_status,
    input  t_in_word   i_in_word,
    input  logic [5:0] i_new_prefix,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_word  o_out_word
);

    localparam int SLOT_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);

    // route table
    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rd_data;

    t_in_word          r_in;
    logic [RTT_W-1:0]  r_sample;
    logic [CNT_W-1:0]  r_filled;
    logic [SLOT_W-1:0] r_idx;
    logic [SLOT_W-1:0] n_idx;
    logic              r_matched;
    logic              r_full;
    logic [RTT_W-1:0]  r_rtt;
    logic [15:0]       r_quo;
    logic [13:0]       r_rem6;
    logic              r_div_phase;
    logic              r_out_valid;
    t_out_word         r_out_word;

    logic [CNT_W-1:0]  w_filled_m1;
    logic [SLOT_W-1:0] w_ins_slot;
    logic [31:0]       w_mask;
    logic [5:0]        w_shift;
    logic              w_hit;
    logic [RTT_W-1:0]  w_avg;
    logic [5:0]        w_new_prefix;
    logic [59:0]       w_prod;
    logic [15:0]       w_quo;
    logic [13:0]       w_qd;
    logic [13:0]       w_rem6;
    logic              w_sat;
    logic [SLOT_W+3:0] w_slot_ext;
    t_out_word         w_out_word;

    assign w_filled_m1 = r_filled - CNT_W'(1);
    assign w_ins_slot  = r_filled[SLOT_W-1:0];

    // slot index, the memory reads the entry it will point to
    always_comb begin
        priority if (i_cmd.load_in) begin
            n_idx = w_filled_m1[SLOT_W-1:0];
        end else if (i_cmd.step_idx) begin
            n_idx = r_idx - SLOT_W'(1);
        end else if (i_cmd.insert) begin
            n_idx = w_ins_slot;
        end else begin
            n_idx = r_idx;
        end
    end

    // prefix compare against the entry at r_idx
    assign w_shift = FULL_PREFIX - r_rd_data.prefix;
    assign w_mask  = (r_rd_data.prefix == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << w_shift[4:0]);
    assign w_hit   = (((r_rd_data.address ^ r_in.dest_address) & w_mask) == 32'd0);

    // mean of sample and stored rtt
    assign w_avg = (r_sample >> 1) + (r_rd_data.rtt_us >> 1);

    assign w_new_prefix = (i_new_prefix > FULL_PREFIX) ? FULL_PREFIX : i_new_prefix;

    // seconds split: quotient by reciprocal, then remainder of rtt >> 6
    assign w_prod = 60'(r_rtt[RTT_W-1:6]) * 60'(SEC_RECIP);
    assign w_quo  = w_prod[SEC_RECIP_SHIFT +: 16];
    assign w_qd   = 14'(r_quo * US_PER_SECOND_ODD);
    assign w_rem6 = r_rtt[19:6] - w_qd;
    assign w_sat  = (r_rtt >= SAT_LIMIT);

    // table memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_mem[r_idx] <= '{address: r_rd_data.address, prefix: r_rd_data.prefix,
                              rtt_us: w_avg};
        end else if (i_cmd.insert) begin
            r_mem[w_ins_slot] <= '{address: r_in.dest_address, prefix: w_new_prefix,
                                   rtt_us: r_sample};
        end
        r_rd_data <= r_mem[n_idx];
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
        end else if (i_cmd.insert) begin
            r_filled <= r_filled + CNT_W'(1);
        end
    end

    // item registers and seconds split
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load_in) begin
            r_in <= i_in_word;
        end
        if (i_cmd.calc_sample) begin
            r_sample <= RTT_W'(r_in.sample_seconds) * RTT_W'(US_PER_SECOND)
                      + RTT_W'(r_in.sample_microseconds);
        end
        if (i_cmd.update) begin
            r_matched <= 1'b1;
            r_full    <= 1'b0;
            r_rtt     <= w_avg;
        end else if (i_cmd.insert) begin
            r_matched <= 1'b0;
            r_full    <= 1'b0;
            r_rtt     <= r_sample;
        end else if (i_cmd.set_full) begin
            r_matched <= 1'b0;
            r_full    <= 1'b1;
        end
        if (i_cmd.update || i_cmd.insert) begin
            r_div_phase <= 1'b0;
        end else if (i_cmd.div_step) begin
            if (!r_div_phase) begin
                r_quo <= w_quo;
            end else begin
                r_rem6 <= w_rem6;
            end
            r_div_phase <= 1'b1;
        end
    end

    // result word
    assign w_slot_ext = {4'b0000, r_idx};
    always_comb begin
        w_out_word = '0;
        if (r_full) begin
            w_out_word.table_full = 1'b1;
        end else begin
            w_out_word.matched               = r_matched;
            w_out_word.entry_slot            = w_slot_ext[3:0];
            w_out_word.smoothed_seconds      = w_sat ? SEC_MAX : r_quo;
            w_out_word.smoothed_microseconds = w_sat ? US_MAX : {r_rem6, r_rtt[5:0]};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out_word <= w_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // status
    assign o_status.empty    = (r_filled == '0);
    assign o_status.full     = (r_filled == CNT_W'(TABLE_ENTRIES));
    assign o_status.hit      = w_hit;
    assign o_status.idx_zero = (r_idx == '0);
    assign o_status.div_last = r_div_phase;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

endmodule

// ----- hw/rtl/prefix_route_rtt_smoother.sv -----
// ----------------------------------------------------------------------------
// prefix_route_rtt_smoother
// Route table that smooths round trip times per destination prefix, with a
// configuration register for the prefix length of new entries.
// ----------------------------------------------------------------------------
//  channel  | signals                              | word
//  ---------+--------------------------------------+-------------------------
//  input    | i_in_valid, o_in_stall, i_in_word    | address and rtt sample
//  output   | o_out_valid, i_out_stall, o_out_word | slot, flags, smoothed rtt
//  config   | psel, penable, pwrite, paddr, pwdata | new_entry_prefix at 0
//
//  an item steps through accept, sample, search (one table entry compared per
//  cycle, at most TABLE_ENTRIES), table write, the split into seconds
//  (quotient, then remainder) and result; a drop skips the write and split
//  reset clears the fill count, so no clearing pass over the table
//  a new word is taken while the previous result waits in the output register
// ----------------------------------------------------------------------------
module prefix_route_rtt_smoother
    import prrs_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [5:0] r_new_prefix;
    logic       w_cfg_write;
    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    // configuration register
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_new_prefix <= RESET_PREFIX;
        end else if (w_cfg_write && (paddr[2] == REG_NEW_ENTRY_PREFIX)) begin
            r_new_prefix <= pwdata[5:0];
        end
    end

    assign prdata = (paddr[2] == REG_NEW_ENTRY_PREFIX) ? {26'd0, r_new_prefix} : 32'd0;

    // sequencer
    prrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // datapath
    prrs_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_in_word    (i_in_word),
        .i_new_prefix (r_new_prefix),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_word   (o_out_word)
    );

endmodule

// ----- tb/prefix_route_rtt_smoother_tb.sv -----
// ----------------------------------------------------------------------------
// prefix_route_rtt_smoother_tb
// Self-checking bench for the prefix route RTT smoother. A directed section
// fills the route table under several prefix settings, runs into saturation
// and the full-table drop. Random bursts then smooth samples into the stored
// entries and keep hitting the full table. Every result word is checked
// field by field against a predicted route table, while the receiver stalls
// on its own changing pattern.
// ----------------------------------------------------------------------------
module prefix_route_rtt_smoother_tb;
    import prrs_pkg::*;

    localparam int TABLE_SLOTS = 16;

    // receiver stall behavior
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BURST
    } t_stall_mode;

    // predicted route table and the result words it still owes
    class route_rtt_predictor;
        bit               slot_used [TABLE_SLOTS];
        logic [31:0]      slot_addr [TABLE_SLOTS];
        logic [5:0]       slot_len  [TABLE_SLOTS];
        logic [RTT_W-1:0] slot_rtt  [TABLE_SLOTS];
        int               filled = 0;
        logic [5:0]       new_prefix = RESET_PREFIX;
        t_out_word        expected_rtt_words [$];
        int               mismatches = 0;

        function void set_new_prefix(logic [5:0] value);
            new_prefix = value;
        endfunction

        function int pending();
            return expected_rtt_words.size();
        endfunction

        function bit prefix_covers(logic [31:0] stored, logic [31:0] addr, logic [5:0] len);
            logic [31:0] diff;
            diff = stored ^ addr;
            if (len == 0) begin
                return 1'b1;
            end
            return (diff >> (FULL_PREFIX - len)) == '0;
        endfunction

        // split microseconds into seconds and microseconds, saturating
        function t_out_word rtt_word(logic hit, int slot, logic [RTT_W-1:0] rtt_us);
            t_out_word   w;
            logic [63:0] secs;
            secs = 64'(rtt_us) / 64'(US_PER_SECOND);
            w.matched    = hit;
            w.entry_slot = 4'(slot);
            w.table_full = 1'b0;
            if (secs > 64'(SEC_MAX)) begin
                w.smoothed_seconds      = SEC_MAX;
                w.smoothed_microseconds = US_MAX;
            end else begin
                w.smoothed_seconds      = secs[15:0];
                w.smoothed_microseconds = 20'(64'(rtt_us) % 64'(US_PER_SECOND));
            end
            return w;
        endfunction

        // search newest to oldest, smooth on hit, insert or drop on miss
        function t_out_word smooth_sample(t_in_word in_w);
            logic [RTT_W-1:0] sample;
            t_out_word        dropped;
            sample = RTT_W'(64'(in_w.sample_seconds) * 64'(US_PER_SECOND)
                            + 64'(in_w.sample_microseconds));
            for (int k = filled - 1; k >= 0; k--) begin
                if (slot_used[k] && prefix_covers(slot_addr[k], in_w.dest_address,
                                                  slot_len[k])) begin
                    slot_rtt[k] = (sample >> 1) + (slot_rtt[k] >> 1);
                    return rtt_word(1'b1, k, slot_rtt[k]);
                end
            end
            if (filled >= TABLE_SLOTS) begin
                dropped = '0;
                dropped.table_full = 1'b1;
                return dropped;
            end
            slot_used[filled] = 1'b1;
            slot_addr[filled] = in_w.dest_address;
            slot_len[filled]  = (new_prefix > FULL_PREFIX) ? FULL_PREFIX : new_prefix;
            slot_rtt[filled]  = sample;
            filled++;
            return rtt_word(1'b0, filled - 1, sample);
        endfunction

        function void note_sample(t_in_word in_w);
            expected_rtt_words.push_back(smooth_sample(in_w));
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            mismatches++;
        endtask

        task check_result(t_out_word got);
            t_out_word want;
            if (expected_rtt_words.size() == 0) begin
                report($sformatf("result word %h with nothing expected", got));
                return;
            end
            want = expected_rtt_words.pop_front();
            if (got.matched !== want.matched)
                report($sformatf("matched %0d, expected %0d", got.matched, want.matched));
            if (got.entry_slot !== want.entry_slot)
                report($sformatf("entry_slot %0d, expected %0d",
                                 got.entry_slot, want.entry_slot));
            if (got.table_full !== want.table_full)
                report($sformatf("table_full %0d, expected %0d",
                                 got.table_full, want.table_full));
            if (got.smoothed_seconds !== want.smoothed_seconds)
                report($sformatf("smoothed_seconds %0d, expected %0d",
                                 got.smoothed_seconds, want.smoothed_seconds));
            if (got.smoothed_microseconds !== want.smoothed_microseconds)
                report($sformatf("smoothed_microseconds %0d, expected %0d",
                                 got.smoothed_microseconds, want.smoothed_microseconds));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_word    i_in_word = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_word   o_out_word;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    route_rtt_predictor route_rtt = new;
    logic [31:0]        seen_addresses [$];

    t_stall_mode stall_mode = STALL_NONE;
    int unsigned mode_timer = 0;
    int unsigned stall_hold = 0;

    prefix_route_rtt_smoother #(
        .TABLE_ENTRIES(TABLE_SLOTS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver stall pattern, mode changes when its timer runs out
    always @(posedge i_clk) begin
        if (mode_timer == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            mode_timer <= $urandom_range(100, 400);
        end else begin
            mode_timer <= mode_timer - 1;
        end
        case (stall_mode)
            STALL_NONE: i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: begin
                if (stall_hold != 0) begin
                    stall_hold  <= stall_hold - 1;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                    if ($urandom_range(0, 15) == 0)
                        stall_hold <= $urandom_range(5, 40);
                end
            end
        endcase
    end

    // result word check
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            route_rtt.check_result(o_out_word);
    end

    // present one word and hold it until taken
    task automatic send(input t_in_word w);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        route_rtt.note_sample(w);
        seen_addresses.push_back(w.dest_address);
    endtask

    task automatic send_fields(input logic [31:0] addr, input logic [15:0] secs,
                               input logic [19:0] usecs);
        t_in_word w;
        w.dest_address        = addr;
        w.sample_seconds      = secs;
        w.sample_microseconds = usecs;
        send(w);
    endtask

    task automatic pause(input int unsigned cycles);
        if (cycles != 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // stop sending until every result word is back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (route_rtt.pending() != 0) @(posedge i_clk);
    endtask

    // setup and access cycle on the register port
    task automatic write_prefix(input logic [5:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_NEW_ENTRY_PREFIX, 2'b00};
        pwdata  <= {26'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        route_rtt.set_new_prefix(value);
    endtask

    // mostly addresses near known entries, some fully random
    function automatic t_in_word random_sample();
        t_in_word    w;
        int unsigned low_bits;
        logic [31:0] mask;
        low_bits = $urandom_range(0, 32);
        mask = (low_bits == 32) ? '1 : ((32'd1 << low_bits) - 1);
        if ($urandom_range(0, 9) < 6)
            w.dest_address = seen_addresses[$urandom_range(0, seen_addresses.size() - 1)]
                             ^ ($urandom & mask);
        else
            w.dest_address = $urandom;
        case ($urandom_range(0, 7))
            0: w.sample_seconds = '0;
            1: w.sample_seconds = SEC_MAX;
            2, 3: w.sample_seconds = 16'($urandom_range(0, 10));
            default: w.sample_seconds = 16'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 7))
            0: w.sample_microseconds = '0;
            1: w.sample_microseconds = '1;
            2: w.sample_microseconds = US_MAX;
            3: w.sample_microseconds = 20'($urandom_range(0, 20'hFFFFF));
            default: w.sample_microseconds = 20'($urandom_range(0, 999999));
        endcase
        return w;
    endfunction

    // stimulus
    initial begin
        logic [5:0]  phase_prefix [6] = '{6'd0, 6'd33, 6'd16, 6'd63, 6'd8, 6'd24};
        int unsigned remaining;
        int unsigned burst;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset prefix, zero sample, sample above 999999 us, saturated insert
        send_fields(32'h0000_0000, 16'd0, 20'd0);
        send_fields(32'h0000_00FF, SEC_MAX, 20'hFFFFF);
        send_fields(32'h02FF_FFFF, SEC_MAX, 20'hFFFFF);
        send_fields(32'h0200_0000, 16'd0, US_MAX);
        drain();

        // full prefix: only the exact address hits
        write_prefix(6'd32);
        send_fields(32'h0300_0001, 16'd1, 20'd500000);
        send_fields(32'h0300_0001, 16'd3, 20'd1);
        send_fields(32'h0300_0000, 16'd2, 20'd250000);
        drain();

        // prefix above 32 behaves as 32
        write_prefix(6'd63);
        send_fields(32'h0400_0005, 16'd0, 20'd999);
        send_fields(32'h0400_0004, 16'd9, 20'd77);
        drain();

        // one-bit prefix covering the upper half of the address space
        write_prefix(6'd1);
        send_fields(32'hFFFF_FFFF, 16'd7, 20'd123456);
        send_fields(32'h8000_0000, 16'd1, 20'd2);
        drain();

        // fill the rest of the table, then drop on a miss
        write_prefix(6'd20);
        for (int k = 0; k < 9; k++)
            send_fields({8'h10 + 8'(k), 24'h00_0ABC}, 16'(k), 20'(k * 1000));
        send_fields(32'h2000_0000, 16'd5, 20'd5);
        send_fields(32'h1800_0FFF, 16'd4, 20'd4);
        drain();

        // random bursts under changing register settings
        foreach (phase_prefix[p]) begin
            write_prefix(phase_prefix[p]);
            remaining = 258;
            while (remaining != 0) begin
                burst = $urandom_range(1, 24);
                while (burst != 0 && remaining != 0) begin
                    send(random_sample());
                    burst--;
                    remaining--;
                end
                pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30));
            end
            drain();
        end

        repeat (40) @(posedge i_clk);
        if (route_rtt.mismatches == 0 && route_rtt.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
